FILE: rtl/tpdq_pkg.sv
// Shared types and constants for the timed packet delay queue.
package tpdq_pkg;

    localparam int TIME_W = 48;
    localparam int DELAY_W = 32;
    localparam int ID_W = 16;
    localparam int CAP_W = 6;
    localparam int KIND_W = 3;

    localparam logic [KIND_W-1:0] KIND_QUEUED   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SEND_NOW = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REJECTED = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RELEASED = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TICK_END = 3'd4;

    typedef struct packed {
        logic [TIME_W-1:0] rel_time;
        logic [ID_W-1:0]   dest;
        logic [ID_W-1:0]   handle;
        logic [ID_W-1:0]   length;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [1:0] {
        RD_POS_M1,
        RD_N,
        RD_I,
        RD_I_P1
    } rd_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_CHK,
        ST_ADD_RD,
        ST_ADD_CMP,
        ST_ADD_INS,
        ST_ADD_OUT,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_REL_RD,
        ST_REL_CUR,
        ST_REL_NXT,
        ST_REL_EMIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic            capture;
        rd_sel_t         rd_sel;
        logic            wr_shift;
        logic            wr_new;
        logic            pos_dec;
        logic            cnt_inc;
        logic            n_inc;
        logic            wait_set;
        logic            cur_load;
        logic            bl_force;
        logic            bl_eval;
        logic            out_load;
        logic [KIND_W-1:0] out_kind;
        logic            i_inc;
        logic            tick_commit;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic delay_zero;
        logic pos_zero;
        logic pos_one;
        logic rd_gt_t;
        logic rd_le_now;
        logic n_at_count;
        logic n_zero;
        logic i_last;
        logic out_free;
    } sts_t;

endpackage

FILE: rtl/tpdq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module tpdq_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/tpdq_ctrl.sv
// Sequencer for add, scan, release and tick-done steps.
module tpdq_ctrl
    import tpdq_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    input  logic s_mode,
    output logic s_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = s_mode ? ST_SCAN_RD : ST_ADD_CHK;
            end
            ST_ADD_CHK: begin
                if (sts.full || sts.delay_zero) begin
                    if (sts.out_free) state_next = ST_IDLE;
                end else begin
                    state_next = sts.pos_zero ? ST_ADD_INS : ST_ADD_RD;
                end
            end
            ST_ADD_RD:  state_next = ST_ADD_CMP;
            ST_ADD_CMP: begin
                if (sts.rd_gt_t && !sts.pos_one) state_next = ST_ADD_RD;
                else                             state_next = ST_ADD_INS;
            end
            ST_ADD_INS: state_next = ST_ADD_OUT;
            ST_ADD_OUT: begin
                if (sts.out_free) state_next = ST_IDLE;
            end
            ST_SCAN_RD: begin
                if (sts.n_at_count) state_next = sts.n_zero ? ST_DONE : ST_REL_RD;
                else                state_next = ST_SCAN_CMP;
            end
            ST_SCAN_CMP: begin
                if (sts.rd_le_now) state_next = ST_SCAN_RD;
                else               state_next = sts.n_zero ? ST_DONE : ST_REL_RD;
            end
            ST_REL_RD:  state_next = ST_REL_CUR;
            ST_REL_CUR: state_next = sts.i_last ? ST_REL_EMIT : ST_REL_NXT;
            ST_REL_NXT: state_next = ST_REL_EMIT;
            ST_REL_EMIT: begin
                if (sts.out_free) state_next = sts.i_last ? ST_DONE : ST_REL_RD;
            end
            ST_DONE: begin
                if (sts.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        cmd.rd_sel = RD_POS_M1;
        cmd.out_kind = KIND_QUEUED;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                cmd.capture = s_valid;
            end
            ST_ADD_CHK: begin
                cmd.out_kind = sts.full ? KIND_REJECTED : KIND_SEND_NOW;
                cmd.out_load = (sts.full || sts.delay_zero) && sts.out_free;
            end
            ST_ADD_RD: cmd.rd_sel = RD_POS_M1;
            ST_ADD_CMP: begin
                // shift the later entry up one slot
                cmd.wr_shift = sts.rd_gt_t;
                cmd.pos_dec = sts.rd_gt_t;
            end
            ST_ADD_INS: begin
                cmd.wr_new = 1'b1;
                cmd.cnt_inc = 1'b1;
            end
            ST_ADD_OUT: begin
                cmd.out_kind = KIND_QUEUED;
                cmd.out_load = sts.out_free;
            end
            ST_SCAN_RD: cmd.rd_sel = RD_N;
            ST_SCAN_CMP: begin
                cmd.n_inc = sts.rd_le_now;
                cmd.wait_set = !sts.rd_le_now;
            end
            ST_REL_RD: cmd.rd_sel = RD_I;
            ST_REL_CUR: begin
                cmd.cur_load = 1'b1;
                cmd.rd_sel = RD_I_P1;
                cmd.bl_force = sts.i_last;
            end
            ST_REL_NXT: cmd.bl_eval = 1'b1;
            ST_REL_EMIT: begin
                cmd.out_kind = KIND_RELEASED;
                cmd.out_load = sts.out_free;
                cmd.i_inc = sts.out_free;
            end
            ST_DONE: begin
                cmd.out_kind = KIND_TICK_END;
                cmd.out_load = sts.out_free;
                cmd.tick_commit = sts.out_free;
            end
            default: cmd = '0;
        endcase
    end

endmodule

FILE: rtl/tpdq_dp.sv
// Datapath: entry store, queue pointers, counters and result register.
module tpdq_dp
    import tpdq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32,
    parameter int BATCH_MAX = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cmd_t                cmd,
    output sts_t                sts,
    input  logic                cfg_valid,
    input  logic [CAP_W-1:0]    cfg_data,
    input  logic [TIME_W-1:0]   s_now_us,
    input  logic [DELAY_W-1:0]  s_delay_us,
    input  logic [ID_W-1:0]     s_dest_id,
    input  logic [ID_W-1:0]     s_packet_handle,
    input  logic [ID_W-1:0]     s_packet_length,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [KIND_W-1:0]   m_kind,
    output logic [ID_W-1:0]     m_out_handle,
    output logic [ID_W-1:0]     m_out_length,
    output logic [ID_W-1:0]     m_out_dest,
    output logic                m_batch_last,
    output logic                m_last,
    output logic                m_pending,
    output logic [TIME_W-1:0]   m_wait_us
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = AW + 1;
    localparam int CMW = (CW > CAP_W) ? CW : CAP_W;
    localparam int RW = $clog2(BATCH_MAX + 1);

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                           input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(off);
        if (sum >= SW'(QUEUE_DEPTH)) sum = sum - SW'(QUEUE_DEPTH);
        return sum[AW-1:0];
    endfunction

    logic [CAP_W-1:0]  cap_reg;
    logic [AW-1:0]     head_reg;
    logic [CW-1:0]     count_reg, pos_reg, n_reg, i_reg;
    logic [RW-1:0]     run_reg;
    logic [TIME_W-1:0] now_reg, t_reg, wait_reg;
    logic [DELAY_W-1:0] delay_reg;
    logic [ID_W-1:0]   dest_reg, handle_reg, length_reg;
    entry_t            cur_reg;
    logic              bl_reg;

    logic              out_valid_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [ID_W-1:0]   oh_reg, ol_reg, od_reg;
    logic              obl_reg, olast_reg, opend_reg;
    logic [TIME_W-1:0] owait_reg;

    entry_t            rd_entry, wr_entry, new_entry;
    logic [ENTRY_W-1:0] rdata;
    logic [AW-1:0]     raddr, waddr;
    logic [CW-1:0]     rd_off;
    logic              pend;
    logic [CW:0]       i_p1;

    assign rd_entry = entry_t'(rdata);
    assign i_p1 = {1'b0, i_reg} + 1'b1;

    always_comb begin
        case (cmd.rd_sel)
            RD_POS_M1: rd_off = pos_reg - 1'b1;
            RD_N:      rd_off = n_reg;
            RD_I:      rd_off = i_reg;
            RD_I_P1:   rd_off = i_p1[CW-1:0];
            default:   rd_off = i_reg;
        endcase
    end

    assign raddr = phys(head_reg, rd_off);
    assign waddr = phys(head_reg, pos_reg);
    assign new_entry = '{rel_time: t_reg, dest: dest_reg,
                         handle: handle_reg, length: length_reg};
    assign wr_entry = cmd.wr_shift ? rd_entry : new_entry;

    tpdq_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_ram (
        .aclk  (aclk),
        .we    (cmd.wr_shift || cmd.wr_new),
        .waddr (waddr),
        .wdata (wr_entry),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign pend = (count_reg != n_reg);

    always_comb begin
        sts.full       = ((cap_reg != '0) && (CMW'(count_reg) >= CMW'(cap_reg))) ||
                         (count_reg >= CW'(QUEUE_DEPTH));
        sts.delay_zero = (delay_reg == '0);
        sts.pos_zero   = (pos_reg == '0);
        sts.pos_one    = (pos_reg == CW'(1));
        sts.rd_gt_t    = (rd_entry.rel_time > t_reg);
        sts.rd_le_now  = (rd_entry.rel_time <= now_reg);
        sts.n_at_count = (n_reg == count_reg);
        sts.n_zero     = (n_reg == '0);
        sts.i_last     = (i_p1 == {1'b0, n_reg});
        sts.out_free   = !out_valid_reg || m_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= '0;
            head_reg <= '0;
            count_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) cap_reg <= cfg_data;
            if (cmd.cnt_inc) count_reg <= count_reg + 1'b1;
            if (cmd.tick_commit) begin
                // drop released entries from the head
                head_reg <= phys(head_reg, n_reg);
                count_reg <= count_reg - n_reg;
            end
            if (cmd.out_load)  out_valid_reg <= 1'b1;
            else if (m_ready)  out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            now_reg <= s_now_us;
            delay_reg <= s_delay_us;
            t_reg <= s_now_us + TIME_W'(s_delay_us);
            dest_reg <= s_dest_id;
            handle_reg <= s_packet_handle;
            length_reg <= s_packet_length;
            pos_reg <= count_reg;
            n_reg <= '0;
            i_reg <= '0;
            run_reg <= '0;
            wait_reg <= '0;
        end
        if (cmd.pos_dec)  pos_reg <= pos_reg - 1'b1;
        if (cmd.n_inc)    n_reg <= n_reg + 1'b1;
        if (cmd.wait_set) wait_reg <= rd_entry.rel_time - now_reg;
        if (cmd.cur_load) cur_reg <= rd_entry;
        if (cmd.bl_force) bl_reg <= 1'b1;
        if (cmd.bl_eval) begin
            bl_reg <= (rd_entry.dest != cur_reg.dest) ||
                      ((RW+1)'(run_reg) + 1'b1 >= (RW+1)'(BATCH_MAX));
        end
        if (cmd.i_inc) begin
            i_reg <= i_p1[CW-1:0];
            run_reg <= bl_reg ? '0 : run_reg + 1'b1;
        end
        if (cmd.out_load) begin
            kind_reg <= cmd.out_kind;
            obl_reg <= 1'b0;
            olast_reg <= 1'b1;
            owait_reg <= '0;
            oh_reg <= handle_reg;
            ol_reg <= length_reg;
            od_reg <= dest_reg;
            opend_reg <= (count_reg != '0);
            case (cmd.out_kind)
                KIND_RELEASED: begin
                    oh_reg <= cur_reg.handle;
                    ol_reg <= cur_reg.length;
                    od_reg <= cur_reg.dest;
                    obl_reg <= bl_reg;
                    olast_reg <= 1'b0;
                    opend_reg <= pend;
                end
                KIND_TICK_END: begin
                    oh_reg <= '0;
                    ol_reg <= '0;
                    od_reg <= '0;
                    owait_reg <= wait_reg;
                    opend_reg <= pend;
                end
                default: ;
            endcase
        end
    end

    assign m_valid = out_valid_reg;
    assign m_kind = kind_reg;
    assign m_out_handle = oh_reg;
    assign m_out_length = ol_reg;
    assign m_out_dest = od_reg;
    assign m_batch_last = obl_reg;
    assign m_last = olast_reg;
    assign m_pending = opend_reg;
    assign m_wait_us = owait_reg;

endmodule

FILE: rtl/timed_packet_delay_queue_unit.sv
// Time-ordered packet delay queue: top level.
// Input channel (s_*): one item is an add (s_mode 0) or a tick (s_mode 1),
// each with the current time. An add gives one result: queued, send now or
// rejected. A tick gives one released result per due entry, earliest first,
// then a tick-done result carrying the wait to the next deadline.
// Entries sit in one RAM as a circular list kept sorted by release time.
// Items are handled one at a time; s_ready is high only between items.
// Add: reject and send now are answered without touching the RAM; a queued
// add compares stored entries from the tail (one RAM read, and a write when
// it shifts up), then writes the new entry. Tick: the scan reads entries
// from the head until a later one or the end; each released result then
// reads its entry and the next one through the registered RAM read.
// Results leave through one output register; a stalled m_ready holds the
// sequencer at its current result until the item is taken.
// cfg_data sets the capacity limit (0: only the RAM depth limits); write it
// only while idle. Reset empties the queue and clears the limit; no RAM
// clearing pass is needed.
module timed_packet_delay_queue_unit
    import tpdq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32,
    parameter int BATCH_MAX = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CAP_W-1:0]   cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_mode,
    input  logic [TIME_W-1:0]  s_now_us,
    input  logic [DELAY_W-1:0] s_delay_us,
    input  logic [ID_W-1:0]    s_dest_id,
    input  logic [ID_W-1:0]    s_packet_handle,
    input  logic [ID_W-1:0]    s_packet_length,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [KIND_W-1:0]  m_kind,
    output logic [ID_W-1:0]    m_out_handle,
    output logic [ID_W-1:0]    m_out_length,
    output logic [ID_W-1:0]    m_out_dest,
    output logic               m_batch_last,
    output logic               m_last,
    output logic               m_pending,
    output logic [TIME_W-1:0]  m_wait_us
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    tpdq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_mode  (s_mode),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    tpdq_dp #(.QUEUE_DEPTH(QUEUE_DEPTH), .BATCH_MAX(BATCH_MAX)) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .cfg_valid       (cfg_valid),
        .cfg_data        (cfg_data),
        .s_now_us        (s_now_us),
        .s_delay_us      (s_delay_us),
        .s_dest_id       (s_dest_id),
        .s_packet_handle (s_packet_handle),
        .s_packet_length (s_packet_length),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_out_handle    (m_out_handle),
        .m_out_length    (m_out_length),
        .m_out_dest      (m_out_dest),
        .m_batch_last    (m_batch_last),
        .m_last          (m_last),
        .m_pending       (m_pending),
        .m_wait_us       (m_wait_us)
    );

endmodule

FILE: rtl/tpdq_checker.sv
// Port-level checks for the timed packet delay queue, bound to the top level.
module tpdq_checker
    import tpdq_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [KIND_W-1:0]  m_kind,
    input logic [ID_W-1:0]    m_out_handle,
    input logic               m_batch_last,
    input logic               m_last,
    input logic               m_pending,
    input logic [TIME_W-1:0]  m_wait_us
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_out_handle))
        else $error("result changed while stalled");

    // accept one item at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item accepted while busy");

    a_release_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_RELEASED |-> !m_last && m_wait_us == '0)
        else $error("release result flagged last");

    a_batch_only_release: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != KIND_RELEASED |-> !m_batch_last && m_last)
        else $error("non-release result has wrong flags");

    a_wait_only_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_wait_us != '0 |-> m_kind == KIND_TICK_END && m_pending)
        else $error("wait reported outside tick done");

endmodule

bind timed_packet_delay_queue_unit tpdq_checker u_tpdq_checker (.*);

FILE: tb/timed_packet_delay_queue_unit_tb.sv
// Self-checking testbench for the timed packet delay queue top level.
`timescale 1ns / 1ps

module timed_packet_delay_queue_unit_tb;
    import tpdq_pkg::*;

    localparam int DEPTH = 32;
    localparam int BATCH = 32;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int LONG_HOLD = 400;
    localparam logic MODE_ADD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef struct {
        logic              mode;
        logic [TIME_W-1:0] now;
        logic [DELAY_W-1:0] delay;
        logic [ID_W-1:0]   dest;
        logic [ID_W-1:0]   handle;
        logic [ID_W-1:0]   length;
    } pkt_item_t;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   handle;
        logic [ID_W-1:0]   length;
        logic [ID_W-1:0]   dest;
        logic              batch_last;
        logic              last;
        logic              pending;
        logic [TIME_W-1:0] wait_us;
    } release_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CAP_W-1:0]   cfg_data;
    logic               s_valid;
    logic               s_ready;
    logic               s_mode;
    logic [TIME_W-1:0]  s_now_us;
    logic [DELAY_W-1:0] s_delay_us;
    logic [ID_W-1:0]    s_dest_id;
    logic [ID_W-1:0]    s_packet_handle;
    logic [ID_W-1:0]    s_packet_length;
    logic               m_valid;
    logic               m_ready;
    logic [KIND_W-1:0]  m_kind;
    logic [ID_W-1:0]    m_out_handle;
    logic [ID_W-1:0]    m_out_length;
    logic [ID_W-1:0]    m_out_dest;
    logic               m_batch_last;
    logic               m_last;
    logic               m_pending;
    logic [TIME_W-1:0]  m_wait_us;

    timed_packet_delay_queue_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode),
        .s_now_us(s_now_us), .s_delay_us(s_delay_us), .s_dest_id(s_dest_id),
        .s_packet_handle(s_packet_handle), .s_packet_length(s_packet_length),
        .m_valid(m_valid), .m_ready(m_ready), .m_kind(m_kind),
        .m_out_handle(m_out_handle), .m_out_length(m_out_length),
        .m_out_dest(m_out_dest), .m_batch_last(m_batch_last), .m_last(m_last),
        .m_pending(m_pending), .m_wait_us(m_wait_us)
    );

    // Shadow copy of the queue contents
    logic [TIME_W-1:0] sh_time[DEPTH];
    logic [ID_W-1:0]   sh_dest[DEPTH];
    logic [ID_W-1:0]   sh_handle[DEPTH];
    logic [ID_W-1:0]   sh_length[DEPTH];
    int                sh_count;
    int                sh_cap;

    pkt_item_t pkt_q[$];
    release_t  release_q[$];
    int        fail_cnt;
    int        loaded_cnt;
    int        taken_cnt;
    int        cycle_cnt;
    int        gap_left;
    int        stall_left;
    int        hold_left;
    logic      hold_req;
    logic      hold_done;
    logic      quiet;
    logic [TIME_W-1:0] t_cur;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic release_t mk_res(logic [KIND_W-1:0] k, logic [ID_W-1:0] h,
                                        logic [ID_W-1:0] l, logic [ID_W-1:0] d,
                                        logic bl, logic lst, logic p,
                                        logic [TIME_W-1:0] w);
        release_t r;
        r.kind = k; r.handle = h; r.length = l; r.dest = d;
        r.batch_last = bl; r.last = lst; r.pending = p; r.wait_us = w;
        return r;
    endfunction

    task automatic predict_release(pkt_item_t it);
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] w;
        logic [KIND_W-1:0] k;
        int pos;
        int n;
        int run;
        logic bl;
        logic p;
        if (it.mode == MODE_ADD) begin
            if ((sh_cap != 0 && sh_count >= sh_cap) || sh_count >= DEPTH) begin
                k = KIND_REJECTED;
            end else if (it.delay == '0) begin
                k = KIND_SEND_NOW;
            end else begin
                t = it.now + TIME_W'(it.delay);
                pos = sh_count;
                // shift later entries up; equal times stay ahead
                while (pos > 0 && sh_time[pos-1] > t) begin
                    sh_time[pos] = sh_time[pos-1];
                    sh_dest[pos] = sh_dest[pos-1];
                    sh_handle[pos] = sh_handle[pos-1];
                    sh_length[pos] = sh_length[pos-1];
                    pos--;
                end
                sh_time[pos] = t;
                sh_dest[pos] = it.dest;
                sh_handle[pos] = it.handle;
                sh_length[pos] = it.length;
                sh_count++;
                k = KIND_QUEUED;
            end
            release_q.push_back(mk_res(k, it.handle, it.length, it.dest, 1'b0, 1'b1,
                                       sh_count > 0, '0));
        end else begin
            n = 0;
            run = 0;
            w = '0;
            while (n < sh_count && sh_time[n] <= it.now) n++;
            p = (sh_count - n) > 0;
            for (int i = 0; i < n; i++) begin
                run++;
                bl = (i + 1 == n) || (sh_dest[i+1] != sh_dest[i]) || (run >= BATCH);
                if (bl) run = 0;
                release_q.push_back(mk_res(KIND_RELEASED, sh_handle[i], sh_length[i],
                                           sh_dest[i], bl, 1'b0, p, '0));
            end
            for (int i = 0; i < sh_count - n; i++) begin
                sh_time[i] = sh_time[i+n];
                sh_dest[i] = sh_dest[i+n];
                sh_handle[i] = sh_handle[i+n];
                sh_length[i] = sh_length[i+n];
            end
            sh_count = sh_count - n;
            if (sh_count > 0 && sh_time[0] > it.now) w = sh_time[0] - it.now;
            release_q.push_back(mk_res(KIND_TICK_END, '0, '0, '0, 1'b0, 1'b1, p, w));
        end
    endtask

    task automatic push_pkt(logic m, logic [TIME_W-1:0] now, logic [DELAY_W-1:0] dly,
                            logic [ID_W-1:0] d, logic [ID_W-1:0] h, logic [ID_W-1:0] l);
        pkt_item_t it;
        it.mode = m; it.now = now; it.delay = dly;
        it.dest = d; it.handle = h; it.length = l;
        pkt_q.push_back(it);
    endtask

    task automatic push_random(int count);
        logic m;
        logic [TIME_W-1:0] now;
        logic [DELAY_W-1:0] dly;
        logic [ID_W-1:0] d;
        int r;
        for (int i = 0; i < count; i++) begin
            m = ($urandom % 10) < 3 ? MODE_TICK : MODE_ADD;
            t_cur = t_cur + TIME_W'($urandom_range(0, 40));
            now = t_cur;
            if ($urandom % 40 == 0) now = TIME_W'({$urandom, $urandom});
            r = $urandom % 20;
            if (r == 0) dly = '0;
            else if (r == 1) dly = $urandom;
            else dly = $urandom_range(1, 150);
            d = ($urandom % 8 == 0) ? ID_W'($urandom) : ID_W'($urandom_range(0, 3));
            push_pkt(m, now, dly, d, ID_W'($urandom), ID_W'($urandom));
        end
    endtask

    // Wait for drain, then let the block settle before touching the register
    task automatic drain();
        do @(posedge aclk);
        while (pkt_q.size() != 0 || s_valid || release_q.size() != 0);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_cap(logic [CAP_W-1:0] v);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data = v;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Driver: hold the item until it is taken, then load the next one
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!(s_valid && taken_cnt != loaded_cnt)) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_valid <= 1'b0;
            end else if (!quiet && ($urandom % 6 == 0)) begin
                gap_left <= $urandom_range(1, 4) - 1;
                s_valid <= 1'b0;
            end else if (pkt_q.size() != 0) begin
                pkt_item_t it;
                it = pkt_q.pop_front();
                s_mode <= it.mode;
                s_now_us <= it.now;
                s_delay_us <= it.delay;
                s_dest_id <= it.dest;
                s_packet_handle <= it.handle;
                s_packet_length <= it.length;
                s_valid <= 1'b1;
                loaded_cnt <= loaded_cnt + 1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver ready, with one long hold-off when requested
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= LONG_HOLD;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (!quiet && ($urandom % 6 == 0)) begin
            stall_left <= $urandom_range(1, 4) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Monitor: predict on input accept, check on result accept
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sh_cap = int'(cfg_data);
            if (s_valid && s_ready) begin
                pkt_item_t it;
                it.mode = s_mode; it.now = s_now_us; it.delay = s_delay_us;
                it.dest = s_dest_id; it.handle = s_packet_handle;
                it.length = s_packet_length;
                predict_release(it);
                taken_cnt <= taken_cnt + 1;
            end
            if (m_valid && m_ready) begin
                if (release_q.size() == 0) begin
                    $error("unexpected result item: kind %0d handle %0h", m_kind,
                           m_out_handle);
                    fail_cnt++;
                end else begin
                    release_t e;
                    e = release_q.pop_front();
                    if (m_kind !== e.kind) begin
                        $error("kind: expected %0d actual %0d", e.kind, m_kind); fail_cnt++;
                    end
                    if (m_out_handle !== e.handle) begin
                        $error("out_handle: expected %0h actual %0h", e.handle,
                               m_out_handle); fail_cnt++;
                    end
                    if (m_out_length !== e.length) begin
                        $error("out_length: expected %0h actual %0h", e.length,
                               m_out_length); fail_cnt++;
                    end
                    if (m_out_dest !== e.dest) begin
                        $error("out_dest: expected %0h actual %0h", e.dest, m_out_dest);
                        fail_cnt++;
                    end
                    if (m_batch_last !== e.batch_last) begin
                        $error("batch_last: expected %0b actual %0b", e.batch_last,
                               m_batch_last); fail_cnt++;
                    end
                    if (m_last !== e.last) begin
                        $error("last: expected %0b actual %0b", e.last, m_last); fail_cnt++;
                    end
                    if (m_pending !== e.pending) begin
                        $error("pending: expected %0b actual %0b", e.pending, m_pending);
                        fail_cnt++;
                    end
                    if (m_wait_us !== e.wait_us) begin
                        $error("wait_us: expected %0h actual %0h", e.wait_us, m_wait_us);
                        fail_cnt++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timed_packet_delay_queue_unit_tb: FAIL");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_mode = 1'b0;
        s_now_us = '0;
        s_delay_us = '0;
        s_dest_id = '0;
        s_packet_handle = '0;
        s_packet_length = '0;
        m_ready = 1'b0;
        sh_count = 0;
        sh_cap = 0;
        fail_cnt = 0;
        loaded_cnt = 0;
        taken_cnt = 0;
        cycle_cnt = 0;
        gap_left = 0;
        stall_left = 0;
        hold_left = 0;
        hold_req = 1'b0;
        hold_done = 1'b0;
        quiet = 1'b0;
        t_cur = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: extremes, wrap, full by depth, one full-size batch
        write_cap('0);
        push_pkt(MODE_TICK, '0, '0, '0, '0, '0);
        push_pkt(MODE_ADD, {TIME_W{1'b1}}, '0, '1, '1, '1);
        push_pkt(MODE_ADD, {TIME_W{1'b1}}, '1, '1, '1, '1);
        push_pkt(MODE_TICK, 48'd100, '0, '1, '1, '1);
        push_pkt(MODE_TICK, 48'hFFFF_FFFE, '0, '0, '0, '0);
        for (int i = 0; i < DEPTH; i++)
            push_pkt(MODE_ADD, 48'd0, 32'd10, 16'h0005, ID_W'(i), ID_W'(i * 3));
        push_pkt(MODE_ADD, 48'd0, 32'd0, 16'h0001, 16'h00AA, 16'h00BB);
        push_pkt(MODE_TICK, 48'd5, '0, '0, '0, '0);
        push_pkt(MODE_TICK, 48'd10, '0, '0, '0, '0);
        push_pkt(MODE_ADD, 48'd0, 32'd50, 16'h0001, 16'h1234, 16'h0040);
        push_pkt(MODE_ADD, 48'd0, 32'd50, 16'h0002, 16'h1235, 16'h0041);
        push_pkt(MODE_ADD, 48'd0, 32'd20, 16'h0001, 16'h1236, 16'h0042);
        push_pkt(MODE_TICK, 48'd30, '0, '0, '0, '0);
        push_pkt(MODE_TICK, 48'd60, '0, '0, '0, '0);
        drain();

        // Random phases over several limits, extremes included
        write_cap(6'd1);
        push_random(50);
        drain();
        write_cap(6'd32);
        hold_req = 1'b1;
        push_random(50);
        drain();
        write_cap(6'd63);
        t_cur = {TIME_W{1'b1}} - 48'd200;
        push_random(40);
        drain();
        write_cap(6'd5);
        push_random(40);
        drain();
        write_cap(6'($urandom_range(2, 31)));
        push_random(40);
        drain();
        write_cap('0);
        quiet = 1'b1;
        push_random(50);
        push_pkt(MODE_TICK, {TIME_W{1'b1}}, '0, '0, '0, '0);
        drain();
        repeat (50) @(posedge aclk);

        if (fail_cnt == 0 && release_q.size() == 0) begin
            $display("timed_packet_delay_queue_unit_tb: PASS");
        end else begin
            $display("timed_packet_delay_queue_unit_tb: FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/tpdq_pkg.sv
rtl/tpdq_ram.sv
rtl/tpdq_ctrl.sv
rtl/tpdq_dp.sv
rtl/timed_packet_delay_queue_unit.sv
rtl/tpdq_checker.sv
tb/timed_packet_delay_queue_unit_tb.sv
